// ===== rtl/fpti_pkg.sv =====
// ----------------------------------------------------------------------------
// fpti_pkg
// Shared types, constants and the compute sequence of the four-point table
// interpolator.
// ----------------------------------------------------------------------------
package fpti_pkg;

  localparam int unsigned TABLE_DEPTH_DEF = 64;
  localparam int unsigned MIN_POINTS      = 4;

  typedef enum logic [1:0] {
    RS_INSIDE = 2'd0,
    RS_BELOW  = 2'd1,
    RS_ABOVE  = 2'd2,
    RS_SHORT  = 2'd3
  } range_st_e;

  typedef enum logic [1:0] {
    RD_ZERO  = 2'd0,
    RD_IDX   = 2'd1,
    RD_FETCH = 2'd2
  } rd_sel_e;

  typedef enum logic [1:0] {
    SK_ONE = 2'd0,
    SK_DIV = 2'd1,
    SK_MUL = 2'd2
  } step_kind_e;

  // Compute sequence. U and V are the two ratios of a basis weight, W is the
  // weight, T accumulates the ordinate term.
  typedef enum logic [4:0] {
    ST_DIFF = 5'd0,  ST_RA   = 5'd1,  ST_RB   = 5'd2,
    ST_A0_U = 5'd3,  ST_A0_V = 5'd4,  ST_A0_W = 5'd5,  ST_A0_T = 5'd6,
    ST_A1_U = 5'd7,  ST_A1_V = 5'd8,  ST_A1_W = 5'd9,  ST_A1_T = 5'd10,
    ST_A2_U = 5'd11, ST_A2_V = 5'd12, ST_A2_W = 5'd13, ST_A2_T = 5'd14,
    ST_PA   = 5'd15,
    ST_B0_U = 5'd16, ST_B0_V = 5'd17, ST_B0_W = 5'd18, ST_B0_T = 5'd19,
    ST_B1_U = 5'd20, ST_B1_V = 5'd21, ST_B1_W = 5'd22, ST_B1_T = 5'd23,
    ST_B2_U = 5'd24, ST_B2_V = 5'd25, ST_B2_W = 5'd26, ST_B2_T = 5'd27,
    ST_PB   = 5'd28, ST_BL_A = 5'd29, ST_BL_B = 5'd30, ST_RES  = 5'd31
  } step_e;

  typedef struct packed {
    logic      load_wr;
    logic      start;
    logic      res_short;
    logic      res_y;
    range_st_e res_st;
    logic      rd_en;
    rd_sel_e   rd_sel;
    logic      idx_one;
    logic      idx_inc;
    logic      set_j;
    logic      fetch_wr;
    logic      exec;
    logic      div_start;
    logic      mul_start;
    logic      out_load;
    step_e     step;
  } ctrl_cmd_t;

  typedef struct packed {
    logic n_short;
    logic q_le_x;
    logic q_lt_x;
    logic q_eq_x;
    logic x_gt_q;
    logic idx_last;
    logic k_last;
    logic ra_div;
    logic div_done;
  } dp_stat_t;

  function automatic step_kind_e step_kind(step_e step);
    step_kind_e k;
    case (step) inside
      ST_DIFF, ST_RB, ST_PA, ST_PB, ST_RES: k = SK_ONE;
      ST_A0_W, ST_A0_T, ST_A1_W, ST_A1_T, ST_A2_W, ST_A2_T,
      ST_B0_W, ST_B0_T, ST_B1_W, ST_B1_T, ST_B2_W, ST_B2_T,
      ST_BL_A, ST_BL_B: k = SK_MUL;
      default: k = SK_DIV;
    endcase
    return k;
  endfunction

endpackage

// ===== rtl/fpti_if.sv =====
// ----------------------------------------------------------------------------
// fpti channel interfaces
// Valid/ready channels for items, results and the point count register.
// ----------------------------------------------------------------------------
interface fpti_in_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic [5:0]         point_index;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic signed [31:0] query_x;

  modport source (output valid, kind, point_index, point_x, point_y, query_x,
                  input ready);
  modport sink   (input valid, kind, point_index, point_x, point_y, query_x,
                  output ready);
endinterface

interface fpti_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] interpolated_value;
  logic [1:0]         range_status;

  modport source (output valid, interpolated_value, range_status, input ready);
  modport sink   (input valid, interpolated_value, range_status, output ready);
endinterface

interface fpti_cfg_if;
  logic       valid;
  logic       ready;
  logic [6:0] point_count;

  modport source (output valid, point_count, input ready);
  modport sink   (input valid, point_count, output ready);
endinterface

// ===== rtl/fpti_div.sv =====
// ----------------------------------------------------------------------------
// fpti_div
// Restoring Q16.16 divider, one quotient bit per cycle, saturating result.
// ----------------------------------------------------------------------------
module fpti_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [32:0] num_i,
  input  logic signed [32:0] den_i,
  output logic               done_o,
  output logic signed [31:0] quo_o
);
  logic        busy_q, done_q;
  logic [4:0]  cnt_q;
  logic [33:0] rem_q;
  logic [31:0] nl_q, quot_q;
  logic [32:0] ad_q;
  logic        neg_q, ovf_q, zero_q;

  logic [32:0] an, ad;
  logic [33:0] r2;
  logic        ge;

  assign an = num_i[32] ? 33'(-num_i) : 33'(num_i);
  assign ad = den_i[32] ? 33'(-den_i) : 33'(den_i);
  assign r2 = {rem_q[32:0], nl_q[31]};
  assign ge = r2 >= {1'b0, ad_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '1;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 5'd1;
        if (cnt_q == 5'd0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // A quotient of 2^32 or more shows up as the top dividend bits already
  // reaching the divisor; the iterations then run on but are ignored.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= 34'(an[32:16]);
      nl_q   <= {an[15:0], 16'h0000};
      ad_q   <= ad;
      neg_q  <= num_i[32] ^ den_i[32];
      ovf_q  <= 33'(an[32:16]) >= ad;
      zero_q <= (num_i == '0);
      quot_q <= '0;
    end else if (busy_q) begin
      rem_q  <= ge ? (r2 - {1'b0, ad_q}) : r2;
      quot_q <= {quot_q[30:0], ge};
      nl_q   <= {nl_q[30:0], 1'b0};
    end
  end

  always_comb begin
    if (zero_q) begin
      quo_o = '0;
    end else if (!neg_q) begin
      quo_o = (ovf_q || quot_q[31]) ? 32'sh7fffffff : $signed(quot_q);
    end else begin
      quo_o = (ovf_q || quot_q > 32'h80000000) ? 32'sh80000000 : $signed(-quot_q);
    end
  end

  assign done_o = done_q;

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q) else $error("divider started while busy");
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q) else $error("divider done longer than one cycle");
  a_done_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && cnt_q == 5'd0 && !start_i) |=> done_q) else $error("divider missed done");

endmodule

// ===== rtl/fpti_dpath.sv =====
// ----------------------------------------------------------------------------
// fpti_dpath
// Point tables, search index, operand selection, multiplier and result regs.
// ----------------------------------------------------------------------------
module fpti_dpath #(
  parameter int unsigned TABLE_DEPTH = fpti_pkg::TABLE_DEPTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  fpti_pkg::ctrl_cmd_t   cmd_i,
  output fpti_pkg::dp_stat_t    stat_o,
  input  logic [5:0]            point_index_i,
  input  logic signed [31:0]    point_x_i,
  input  logic signed [31:0]    point_y_i,
  input  logic signed [31:0]    query_x_i,
  input  logic                  cfg_we_i,
  input  logic [6:0]            cfg_count_i,
  output logic signed [31:0]    out_value_o,
  output logic [1:0]            out_status_o
);
  import fpti_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned NW = $clog2(TABLE_DEPTH + 1);
  localparam logic signed [65:0] S32_MAX_W = 66'sd2147483647;
  localparam logic signed [65:0] S32_MIN_W = -66'sd2147483648;

  function automatic logic signed [32:0] sx(logic signed [31:0] v);
    return {v[31], v};
  endfunction

  function automatic logic signed [31:0] sat32(logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > S32_MAX_W) r = 32'sh7fffffff;
    else if (v < S32_MIN_W) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  // Tables
  logic [31:0] xmem [TABLE_DEPTH];
  logic [31:0] ymem [TABLE_DEPTH];
  logic [15:0] slot_ext;
  logic        slot_ok;
  logic [AW-1:0] rd_addr;
  logic signed [31:0] x_rd_q, y_rd_q;

  // Query state
  logic [6:0]         count_q;
  logic [15:0]        cnt_ext, n_cur;
  logic [NW-1:0]      n_q;
  logic signed [31:0] q_q;
  logic [AW-1:0]      idx_q, j_q;
  logic [1:0]         k_q;
  logic [15:0]        idx_ext, n_ext, j_last, j_mid;
  logic               ra_one_q, ra_div_q;
  logic signed [31:0] xf [4];
  logic signed [31:0] yf [4];

  // Compute registers
  logic signed [32:0] d_q [4];
  logic signed [32:0] p0_q, p1_q, p2_q, p3_q, p4_q;
  logic signed [31:0] ra_q, rb_q, rat_u_q, rat_v_q, pa_q, pb_q;
  logic signed [32:0] w_q;
  logic signed [33:0] acc_q;
  logic signed [31:0] res_val_q;
  range_st_e          res_st_q;
  logic signed [31:0] out_value_q;
  logic [1:0]         out_status_q;

  logic signed [32:0] div_num, div_den, mul_a, mul_b;
  logic signed [31:0] div_quo, mq;
  logic               div_done;
  logic signed [65:0] prod_q, prod_sh, qv;
  logic signed [65:0] rb_w;

  assign slot_ext = 16'(point_index_i);
  assign slot_ok  = slot_ext < 16'(TABLE_DEPTH);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_wr && slot_ok) begin
      xmem[slot_ext[AW-1:0]] <= point_x_i;
      ymem[slot_ext[AW-1:0]] <= point_y_i;
    end
  end

  always_comb begin
    case (cmd_i.rd_sel)
      RD_ZERO:  rd_addr = '0;
      RD_IDX:   rd_addr = idx_q;
      RD_FETCH: rd_addr = j_q + AW'(k_q);
      default:  rd_addr = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      x_rd_q <= xmem[rd_addr];
      y_rd_q <= ymem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cfg_we_i) begin
      count_q <= cfg_count_i;
    end
  end

  assign cnt_ext = 16'(count_q);
  assign n_cur   = (cnt_ext > 16'(TABLE_DEPTH)) ? 16'(TABLE_DEPTH) : cnt_ext;
  assign idx_ext = 16'(idx_q);
  assign n_ext   = 16'(n_q);
  assign j_last  = n_ext - 16'(MIN_POINTS);
  assign j_mid   = idx_ext - 16'd2;

  // Search and fetch bookkeeping
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      n_q <= n_cur[NW-1:0];
      q_q <= query_x_i;
    end
    if (cmd_i.idx_one) begin
      idx_q <= AW'(1);
    end else if (cmd_i.idx_inc) begin
      idx_q <= idx_q + AW'(1);
    end
    if (cmd_i.set_j) begin
      k_q <= 2'd0;
      if (idx_ext == 16'd1) begin
        j_q      <= '0;
        ra_one_q <= 1'b1;
        ra_div_q <= 1'b0;
      end else if (idx_ext + 16'd1 >= n_ext) begin
        j_q      <= j_last[AW-1:0];
        ra_one_q <= 1'b0;
        ra_div_q <= 1'b0;
      end else begin
        j_q      <= j_mid[AW-1:0];
        ra_one_q <= 1'b0;
        ra_div_q <= 1'b1;
      end
    end else if (cmd_i.fetch_wr) begin
      xf[k_q] <= x_rd_q;
      yf[k_q] <= y_rd_q;
      k_q     <= k_q + 2'd1;
    end
  end

  assign stat_o.n_short  = n_cur < 16'(MIN_POINTS);
  assign stat_o.q_le_x   = q_q <= x_rd_q;
  assign stat_o.q_lt_x   = q_q < x_rd_q;
  assign stat_o.q_eq_x   = q_q == x_rd_q;
  assign stat_o.x_gt_q   = x_rd_q > q_q;
  assign stat_o.idx_last = (idx_ext + 16'd1) == n_ext;
  assign stat_o.k_last   = (k_q == 2'd3);
  assign stat_o.ra_div   = ra_div_q;
  assign stat_o.div_done = div_done;

  // Divider operands: each ratio is a query offset over a point spacing.
  always_comb begin
    div_num = '0;
    div_den = '0;
    case (cmd_i.step)
      ST_RA:   begin div_num = -d_q[2]; div_den = p1_q; end
      ST_A0_U: begin div_num = d_q[1];  div_den = p0_q; end
      ST_A0_V: begin div_num = d_q[2];  div_den = p3_q; end
      ST_A1_U: begin div_num = d_q[0];  div_den = p0_q; end
      ST_A1_V: begin div_num = d_q[2];  div_den = p1_q; end
      ST_A2_U: begin div_num = d_q[0];  div_den = p3_q; end
      ST_A2_V: begin div_num = d_q[1];  div_den = p1_q; end
      ST_B0_U: begin div_num = d_q[2];  div_den = p1_q; end
      ST_B0_V: begin div_num = d_q[3];  div_den = p4_q; end
      ST_B1_U: begin div_num = d_q[1];  div_den = p1_q; end
      ST_B1_V: begin div_num = d_q[3];  div_den = p2_q; end
      ST_B2_U: begin div_num = d_q[1];  div_den = p4_q; end
      ST_B2_V: begin div_num = d_q[2];  div_den = p2_q; end
      default: ;
    endcase
  end

  fpti_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.step)
      ST_A0_W, ST_A1_W, ST_A2_W, ST_B0_W, ST_B1_W, ST_B2_W: begin
        mul_a = sx(rat_u_q);
        mul_b = sx(rat_v_q);
      end
      ST_A0_T: begin mul_a = sx(yf[0]); mul_b = w_q; end
      ST_A1_T: begin mul_a = sx(yf[1]); mul_b = w_q; end
      ST_A2_T: begin mul_a = sx(yf[2]); mul_b = w_q; end
      ST_B0_T: begin mul_a = sx(yf[1]); mul_b = w_q; end
      ST_B1_T: begin mul_a = sx(yf[2]); mul_b = w_q; end
      ST_B2_T: begin mul_a = sx(yf[3]); mul_b = w_q; end
      ST_BL_A: begin mul_a = sx(ra_q);  mul_b = sx(pa_q); end
      ST_BL_B: begin mul_a = sx(rb_q);  mul_b = sx(pb_q); end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_start) begin
      prod_q <= $signed({{33{mul_a[32]}}, mul_a}) * $signed({{33{mul_b[32]}}, mul_b});
    end
  end

  // Scale back by 2^16 with truncation toward zero, then saturate.
  assign prod_sh = prod_q >>> 16;
  assign qv      = prod_sh + 66'((prod_q[65] && (prod_q[15:0] != 16'h0000)) ? 1 : 0);
  assign mq      = sat32(qv);
  assign rb_w    = 66'sd65536 - 66'(ra_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_short) begin
      res_val_q <= '0;
      res_st_q  <= RS_SHORT;
    end else if (cmd_i.res_y) begin
      res_val_q <= y_rd_q;
      res_st_q  <= cmd_i.res_st;
    end else if (cmd_i.exec) begin
      case (cmd_i.step)
        ST_DIFF: begin
          d_q[0] <= sx(q_q) - sx(xf[0]);
          d_q[1] <= sx(q_q) - sx(xf[1]);
          d_q[2] <= sx(q_q) - sx(xf[2]);
          d_q[3] <= sx(q_q) - sx(xf[3]);
          p0_q   <= sx(xf[1]) - sx(xf[0]);
          p1_q   <= sx(xf[2]) - sx(xf[1]);
          p2_q   <= sx(xf[3]) - sx(xf[2]);
          p3_q   <= sx(xf[2]) - sx(xf[0]);
          p4_q   <= sx(xf[3]) - sx(xf[1]);
        end
        ST_RA:   ra_q <= ra_div_q ? div_quo : (ra_one_q ? 32'sd65536 : 32'sd0);
        ST_RB:   rb_q <= sat32(rb_w);
        ST_A0_U, ST_A1_U, ST_A2_U, ST_B0_U, ST_B1_U, ST_B2_U: rat_u_q <= div_quo;
        ST_A0_V, ST_A1_V, ST_A2_V, ST_B0_V, ST_B1_V, ST_B2_V: rat_v_q <= div_quo;
        ST_A0_W, ST_A2_W, ST_B0_W, ST_B2_W: w_q <= sx(mq);
        ST_A1_W, ST_B1_W: w_q <= -sx(mq);
        ST_A0_T, ST_B0_T, ST_BL_A: acc_q <= 34'(mq);
        ST_A1_T, ST_A2_T, ST_B1_T, ST_B2_T, ST_BL_B: acc_q <= acc_q + 34'(mq);
        ST_PA:   pa_q <= sat32(66'(acc_q));
        ST_PB:   pb_q <= sat32(66'(acc_q));
        ST_RES: begin
          res_val_q <= sat32(66'(acc_q));
          res_st_q  <= RS_INSIDE;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_value_q  <= res_val_q;
      out_status_q <= res_st_q;
    end
  end

  assign out_value_o  = out_value_q;
  assign out_status_o = out_status_q;

endmodule

// ===== rtl/fpti_ctrl.sv =====
// ----------------------------------------------------------------------------
// fpti_ctrl
// Sequencer for table loads, the point search, neighbor fetch and compute.
// ----------------------------------------------------------------------------
module fpti_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                kind_i,
  output logic                in_ready_o,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output fpti_pkg::ctrl_cmd_t cmd_o,
  input  fpti_pkg::dp_stat_t  stat_i
);
  import fpti_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE = 11'b00000000001,
    S_RD0  = 11'b00000000010,
    S_CHK0 = 11'b00000000100,
    S_RDI  = 11'b00000001000,
    S_CHKI = 11'b00000010000,
    S_FRD  = 11'b00000100000,
    S_FWR  = 11'b00001000000,
    S_EXEC = 11'b00010000000,
    S_DIVW = 11'b00100000000,
    S_MULW = 11'b01000000000,
    S_DONE = 11'b10000000000
  } state_e;

  state_e     state_q, state_d;
  step_e      step_q, step_d;
  logic       out_valid_q;
  ctrl_cmd_t  cmd;
  step_e      step_nx;

  assign step_nx = step_e'(step_q + 5'd1);

  always_comb begin
    cmd        = '0;
    cmd.step   = step_q;
    cmd.rd_sel = RD_ZERO;
    cmd.res_st = RS_INSIDE;
    state_d    = state_q;
    step_d     = step_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (!kind_i) begin
            cmd.load_wr = 1'b1;
          end else begin
            cmd.start = 1'b1;
            if (stat_i.n_short) begin
              cmd.res_short = 1'b1;
              state_d       = S_DONE;
            end else begin
              state_d = S_RD0;
            end
          end
        end
      end
      S_RD0: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_ZERO;
        state_d    = S_CHK0;
      end
      S_CHK0: begin
        if (stat_i.q_le_x) begin
          cmd.res_y  = 1'b1;
          cmd.res_st = stat_i.q_lt_x ? RS_BELOW : RS_INSIDE;
          state_d    = S_DONE;
        end else begin
          cmd.idx_one = 1'b1;
          state_d     = S_RDI;
        end
      end
      S_RDI: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_IDX;
        state_d    = S_CHKI;
      end
      S_CHKI: begin
        if (stat_i.q_eq_x) begin
          cmd.res_y = 1'b1;
          state_d   = S_DONE;
        end else if (stat_i.x_gt_q) begin
          cmd.set_j = 1'b1;
          state_d   = S_FRD;
        end else if (stat_i.idx_last) begin
          // The last read point is the final one of the table.
          cmd.res_y  = 1'b1;
          cmd.res_st = RS_ABOVE;
          state_d    = S_DONE;
        end else begin
          cmd.idx_inc = 1'b1;
          state_d     = S_RDI;
        end
      end
      S_FRD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_FETCH;
        state_d    = S_FWR;
      end
      S_FWR: begin
        cmd.fetch_wr = 1'b1;
        if (stat_i.k_last) begin
          step_d  = ST_DIFF;
          state_d = S_EXEC;
        end else begin
          state_d = S_FRD;
        end
      end
      S_EXEC: begin
        case (step_kind(step_q))
          SK_ONE: begin
            cmd.exec = 1'b1;
            if (step_q == ST_RES) begin
              state_d = S_DONE;
            end else begin
              step_d = step_nx;
            end
          end
          SK_DIV: begin
            // Weight ra is a constant at both ends of the table.
            if (step_q == ST_RA && !stat_i.ra_div) begin
              cmd.exec = 1'b1;
              step_d   = step_nx;
            end else begin
              cmd.div_start = 1'b1;
              state_d       = S_DIVW;
            end
          end
          SK_MUL: begin
            cmd.mul_start = 1'b1;
            state_d       = S_MULW;
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_DIVW: begin
        if (stat_i.div_done) begin
          cmd.exec = 1'b1;
          step_d   = step_nx;
          state_d  = S_EXEC;
        end
      end
      S_MULW: begin
        cmd.exec = 1'b1;
        step_d   = step_nx;
        state_d  = S_EXEC;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd.out_load = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= ST_DIFF;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      if (cmd.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign cmd_o       = cmd;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  a_done_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && !out_valid_q) |=> out_valid_q)
    else $error("finished result not moved to the output register");
  a_div_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat_i.div_done |-> state_q == S_DIVW)
    else $error("divider finished outside its wait state");

endmodule

// ===== rtl/four_point_table_interpolator.sv =====
// ----------------------------------------------------------------------------
// four_point_table_interpolator
// Table of ascending Q16.16 points with blended parabolic interpolation.
// ----------------------------------------------------------------------------
//  Channel  Direction  Beat carries
//  in_if    sink       kind, point_index, point_x, point_y, query_x
//  out_if   source     interpolated_value, range_status (one per query)
//  cfg_if   sink       point_count
//
// A load beat is written in the cycle it is accepted. A query scans the
// abscissa table one point at a time, fetches four neighbors, then runs up
// to 13 divisions in the shared serial divider plus 14 multiplies. Early
// exits (short table, below, exact hit, above) finish before the fetch.
// Reset clears the point count; the tables are undefined until loaded.
// A finished result sits in the output register while the next beat is taken.
// ----------------------------------------------------------------------------
module four_point_table_interpolator #(
  parameter int unsigned TABLE_DEPTH = fpti_pkg::TABLE_DEPTH_DEF
) (
  input logic         clk_i,
  input logic         rst_ni,
  fpti_in_if.sink     in_if,
  fpti_out_if.source  out_if,
  fpti_cfg_if.sink    cfg_if
);
  import fpti_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  assign cfg_if.ready = 1'b1;

  fpti_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_if.valid),
    .kind_i     (in_if.kind),
    .in_ready_o (in_if.ready),
    .out_ready_i(out_if.ready),
    .out_valid_o(out_if.valid),
    .cmd_o      (cmd),
    .stat_i     (stat)
  );

  fpti_dpath #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .point_index_i(in_if.point_index),
    .point_x_i    (in_if.point_x),
    .point_y_i    (in_if.point_y),
    .query_x_i    (in_if.query_x),
    .cfg_we_i     (cfg_if.valid),
    .cfg_count_i  (cfg_if.point_count),
    .out_value_o  (out_if.interpolated_value),
    .out_status_o (out_if.range_status)
  );

endmodule
